>>> rtl/core/sab_pkg.sv
// Shared types, key codes and translation tables for the scancode buffer.
package sab_pkg;

  localparam int BUFFER_DEPTH_DEF = 256;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;
  localparam int         BREAK_BIT  = 7;

  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Command handed from the classifier to the buffer side
  typedef struct packed {
    logic       is_read;
    logic       has_char;
    logic [7:0] ch;
  } sab_cmd_t;

  // Unshifted German layout, make codes 0x00 to 0x3F
  localparam logic [7:0] BASE_MAP [64] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'hDF, 8'hB4, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'hFC, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF6,
    8'hE4, 8'h5E, 8'h00, 8'h23, 8'h79, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Shifted German layout, make codes 0x00 to 0x3F
  localparam logic [7:0] SHIFT_MAP [64] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'hA7, 8'h24, 8'h25, 8'h26,
    8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h60, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'hDC, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hD6,
    8'hC4, 8'h60, 8'h00, 8'h27, 8'h59, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

>>> rtl/core/sab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/sab_front.sv
// Front end: tracks shift and caps lock and turns each transaction into a command.
module sab_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              action,
  input  logic [7:0]        scancode,
  output sab_pkg::sab_cmd_t cmd
);
  import sab_pkg::*;

  logic       shift_held, shift_held_next;
  logic       caps_locked, caps_locked_next;
  logic [5:0] idx;
  logic [7:0] base_ch;
  logic [7:0] shift_ch;
  logic       in_table;
  logic       is_shift_key;

  assign idx          = scancode[5:0];
  assign base_ch      = BASE_MAP[idx];
  assign shift_ch     = SHIFT_MAP[idx];
  assign in_table     = (scancode[7:6] == 2'b00);
  assign is_shift_key = (scancode[6:0] == KEY_LSHIFT) || (scancode[6:0] == KEY_RSHIFT);

  always_comb begin
    shift_held_next  = shift_held;
    caps_locked_next = caps_locked;
    cmd.is_read      = action;
    cmd.has_char     = 1'b0;
    cmd.ch           = base_ch;
    if (!action) begin
      if (scancode == PREFIX_EXT) begin
        // extended prefix: ignore
      end else if (scancode[BREAK_BIT]) begin
        if (is_shift_key) begin
          shift_held_next = 1'b0;
        end
      end else if (is_shift_key) begin
        shift_held_next = 1'b1;
      end else if (scancode[6:0] == KEY_CAPS) begin
        caps_locked_next = !caps_locked;
      end else if (in_table && base_ch != 8'h00) begin
        if (shift_held) begin
          cmd.has_char = (shift_ch != 8'h00);
          cmd.ch       = shift_ch;
        end else begin
          cmd.has_char = 1'b1;
          // caps lock only raises letters
          if (caps_locked && base_ch >= LOWER_A && base_ch <= LOWER_Z) begin
            cmd.ch = base_ch - CASE_DELTA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      caps_locked <= 1'b0;
    end else if (take) begin
      shift_held  <= shift_held_next;
      caps_locked <= caps_locked_next;
    end
  end

endmodule

>>> rtl/core/sab_cmd_queue.sv
// Two-entry command queue between the front end and the buffer side.
module sab_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sab_pkg::sab_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sab_pkg::sab_cmd_t head_cmd
);
  import sab_pkg::*;

  sab_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count, count_next;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 2'd1;
    end else if (do_pop && !do_push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

>>> rtl/core/sab_back.sv
// Back end: ring buffer of characters, read port and result register.
module sab_back #(
  parameter int BUFFER_DEPTH = sab_pkg::BUFFER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sab_pkg::sab_cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              char_valid,
  output logic [7:0]        character,
  output logic              dropped,
  output logic              available
);
  import sab_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);

  logic [PTR_W-1:0] wp, wp_next, wp_inc;
  logic [PTR_W-1:0] rp, rp_next, rp_inc;
  logic             rd_ok, wr_ok, wr_drop;
  logic             p_valid;
  logic             p_char_valid, p_dropped, p_available;
  logic             p_adv;
  logic [7:0]       rd_data;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign p_adv  = p_valid && (!out_valid || !out_stall);
  assign pop    = head_valid && (!p_valid || p_adv);
  assign wp_inc = ptr_inc(wp);
  assign rp_inc = ptr_inc(rp);

  always_comb begin
    rd_ok   = head_cmd.is_read && (rp != wp);
    wr_drop = !head_cmd.is_read && head_cmd.has_char && (wp_inc == rp);
    wr_ok   = !head_cmd.is_read && head_cmd.has_char && (wp_inc != rp);
    rp_next = rd_ok ? rp_inc : rp;
    wp_next = wr_ok ? wp_inc : wp;
  end

  sab_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (pop && wr_ok),
    .wr_addr (wp),
    .wr_data (head_cmd.ch),
    .rd_en   (pop && rd_ok),
    .rd_addr (rp),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      p_char_valid <= rd_ok;
      p_dropped    <= wr_drop;
      p_available  <= (rp_next != wp_next);
    end
    if (p_adv) begin
      char_valid <= p_char_valid;
      character  <= p_char_valid ? rd_data : 8'h00;
      dropped    <= p_dropped;
      available  <= p_available;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        wp <= wp_next;
        rp <= rp_next;
      end
      // hold the read stage until the result register frees up
      if (pop) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/scancode_to_ascii_buffered_core.sv
// Top level of the set 1 scancode translator with character buffer.
//
// Input channel (in_valid / in_stall): action = 0 carries a scancode byte,
// action = 1 asks for one buffered character. Every input transaction gives
// exactly one result transaction on the output channel (out_valid /
// out_stall) carrying char_valid, character, dropped and available.
// Throughput: one transaction per cycle while out_stall does not hold the
// result path; the front end classifies and queues a command, the back end
// does one buffer access per cycle through a RAM with registered read data,
// then loads the result register.
// A two-entry command queue separates the sides; in_stall rises only when it
// is full, which happens when out_stall holds the result path.
// A full buffer keeps BUFFER_DEPTH - 1 characters; new ones are dropped.
// Reset clears the pointers, the shift and caps lock flags and the stage valids;
// buffer contents are not cleared and need no clearing pass.
// While out_valid and out_stall are high the result register holds its value.
module scancode_to_ascii_buffered_core #(
  parameter int BUFFER_DEPTH = sab_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       char_valid,
  output logic [7:0] character,
  output logic       dropped,
  output logic       available
);
  import sab_pkg::*;

  sab_cmd_t front_cmd;
  sab_cmd_t head_cmd;
  logic     q_full;
  logic     head_valid;
  logic     pop;
  logic     take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  sab_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .action   (action),
    .scancode (scancode),
    .cmd      (front_cmd)
  );

  sab_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sab_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_valid (char_valid),
    .character  (character),
    .dropped    (dropped),
    .available  (available)
  );

endmodule

>>> rtl/core/sab_checker.sv
// Port-level checker for the scancode buffer, bound to the top level.
module sab_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       char_valid,
  input logic [7:0] character,
  input logic       dropped,
  input logic       available
);

  // a result without a character, from a scancode or an empty read, has a zero character
  a_zero_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> character == 8'h00)
    else $error("character not zero without char_valid");

  // a drop means the buffer was full, so it cannot be empty afterwards
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> available)
    else $error("dropped with empty buffer");

  a_drop_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(dropped && char_valid))
    else $error("read and drop in one transaction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(character) && $stable(available))
    else $error("stalled result changed");

endmodule

bind scancode_to_ascii_buffered_core sab_checker u_sab_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .char_valid (char_valid),
  .character  (character),
  .dropped    (dropped),
  .available  (available)
);

>>> bench/tb_scancode_to_ascii_buffered_core.sv
// Self-checking testbench for the buffered set 1 scancode to Latin-1 translator.
module tb_scancode_to_ascii_buffered_core;
  import sab_pkg::*;

  localparam int DEPTH        = BUFFER_DEPTH_DEF;
  localparam int TABLE_LEN    = 58;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTS   = 40;

  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] character;
    logic       dropped;
    logic       available;
  } kbd_res_t;

  typedef struct packed {
    logic       act;
    logic [7:0] code;
    logic       typed;
    kbd_res_t   res;
  } stim_row_t;

  localparam kbd_res_t NOTHING = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = ACT_SCAN;
  logic [7:0] scancode = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       char_valid;
  logic [7:0] character;
  logic       dropped;
  logic       available;

  scancode_to_ascii_buffered_core #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .scancode   (scancode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_valid (char_valid),
    .character  (character),
    .dropped    (dropped),
    .available  (available)
  );

  always #5 clk = ~clk;

  // German layout, unshifted and shifted, make codes 0x00 to 0x39
  logic [7:0] base_keys [TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'hDF, 8'hB4, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'hFC, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF6,
    8'hE4, 8'h5E, 8'h00, 8'h23, 8'h79, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
    8'h00, 8'h20
  };
  logic [7:0] shifted_keys [TABLE_LEN] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'hA7, 8'h24, 8'h25, 8'h26,
    8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h60, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'hDC, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hD6,
    8'hC4, 8'h60, 8'h00, 8'h27, 8'h59, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A,
    8'h00, 8'h20
  };

  // Directed rows; a typed result replaces the predicted one for that row
  stim_row_t directed_rows [25] = '{
    '{ACT_READ, 8'h00, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h00, 1'b1, NOTHING},
    '{ACT_SCAN, 8'hE0, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h3B, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h7F, 1'b1, NOTHING},
    '{ACT_SCAN, 8'hFF, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h3A, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h1E, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{ACT_READ, 8'hFF, 1'b1, '{1'b1, 8'h41, 1'b0, 1'b0}},
    '{ACT_SCAN, 8'h2A, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h01, 1'b1, NOTHING},
    '{ACT_SCAN, 8'h0D, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h1A, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h1E, 1'b0, NOTHING},
    '{ACT_SCAN, 8'hAA, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h36, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h29, 1'b0, NOTHING},
    '{ACT_SCAN, 8'hB6, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h1E, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h3A, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h01, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h1D, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h38, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h39, 1'b0, NOTHING},
    '{ACT_SCAN, 8'h0C, 1'b0, NOTHING}
  };

  // Predictor state
  logic [7:0] buffered_chars [DEPTH];
  int         wr_ptr = 0;
  int         rd_ptr = 0;
  bit         shift_down = 1'b0;
  bit         caps_on = 1'b0;

  kbd_res_t   awaited_results [$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         items_taken = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  bit         hold_off = 1'b0;

  function automatic kbd_res_t next_kbd_result(input logic act, input logic [7:0] code);
    kbd_res_t   r;
    logic [7:0] ch;
    logic [6:0] make;
    r = NOTHING;
    ch = 8'h00;
    make = code[6:0];
    if (act == ACT_READ) begin
      if (rd_ptr != wr_ptr) begin
        r.char_valid = 1'b1;
        r.character = buffered_chars[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH;
      end
    end else if (code == PREFIX_EXT) begin
      // extended prefix: ignore
    end else if (code[BREAK_BIT]) begin
      if (make == KEY_LSHIFT || make == KEY_RSHIFT) shift_down = 1'b0;
    end else if (make == KEY_LSHIFT || make == KEY_RSHIFT) begin
      shift_down = 1'b1;
    end else if (make == KEY_CAPS) begin
      caps_on = !caps_on;
    end else if (code < TABLE_LEN && base_keys[code] != 8'h00) begin
      if (shift_down) begin
        ch = shifted_keys[code];
      end else begin
        ch = base_keys[code];
        if (caps_on && ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_DELTA;
      end
      if (ch != 8'h00) begin
        if ((wr_ptr + 1) % DEPTH == rd_ptr) begin
          r.dropped = 1'b1;
        end else begin
          buffered_chars[wr_ptr] = ch;
          wr_ptr = (wr_ptr + 1) % DEPTH;
        end
      end
    end
    r.available = (rd_ptr != wr_ptr);
    return r;
  endfunction

  function automatic logic [7:0] pick_scancode();
    int unsigned n;
    n = $urandom_range(0, 99);
    if (n < 55) return 8'($urandom_range(1, 8'h39));
    if (n < 63) return {1'($urandom_range(0, 1)), ($urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT)};
    if (n < 67) return {1'b0, KEY_CAPS};
    if (n < 72) return PREFIX_EXT;
    if (n < 80) return {1'b1, 7'($urandom_range(1, 8'h39))};
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("[cycle %0d] result %0d: %s", cycle_count, results_seen, what);
    mismatches++;
  endtask

  // Offer one transaction; open a gap first when the current burst is used up
  task automatic offer_item(input logic act, input logic [7:0] code, input logic typed,
                            input kbd_res_t typed_res);
    kbd_res_t r;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    scancode <= code;
    do @(posedge clk); while (in_stall);
    r = next_kbd_result(act, code);
    awaited_results.push_back(typed ? typed_res : r);
    items_taken++;
  endtask

  initial begin
    int sent;
    int phase;
    int read_pct;
    int span;
    sent = 0;
    phase = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].act, directed_rows[i].code, directed_rows[i].typed,
                 directed_rows[i].res);

    // Cycle through fill, drain and mixed phases so the buffer fills, wraps and empties
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0: begin
          read_pct = 2;
          span = $urandom_range(450, 600);
        end
        1: begin
          read_pct = 85;
          span = $urandom_range(200, 300);
        end
        default: begin
          read_pct = 45;
          span = $urandom_range(150, 250);
        end
      endcase
      for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 99) < read_pct)
          offer_item(ACT_READ, 8'($urandom_range(0, 255)), 1'b0, NOTHING);
        else
          offer_item(ACT_SCAN, pick_scancode(), 1'b0, NOTHING);
        sent++;
      end
      phase++;
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Receiver stall pattern with randomly chosen modes
  int stall_mode = 0;
  int stall_mode_left = 0;

  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_mode_left <= $urandom_range(20, 120);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= hold_off;
      1: out_stall <= hold_off || ($urandom_range(0, 3) == 0);
      2: out_stall <= hold_off || ($urandom_range(0, 3) != 0);
      default: out_stall <= hold_off || !out_stall;
    endcase
  end

  // Hold off the receiver for long stretches so the input side backs up
  initial begin
    while (items_taken < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
    while (items_taken < 1300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : check_results
    kbd_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result transaction with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        if (char_valid !== want.char_valid)
          report_mismatch($sformatf("char_valid got %b want %b", char_valid, want.char_valid));
        if (character !== want.character)
          report_mismatch($sformatf("character got %h want %h", character, want.character));
        if (dropped !== want.dropped)
          report_mismatch($sformatf("dropped got %b want %b", dropped, want.dropped));
        if (available !== want.available)
          report_mismatch($sformatf("available got %b want %b", available, want.available));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
